[rtl/assert_macros.svh]
// Assertion macros shared by the loop difference engine RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/lde_pkg.sv]
// Shared constants, types and helpers of the loop difference engine
package lde_pkg;
    localparam int STACK_DEPTH = 512;
    localparam int TABLE_DEPTH = 64;
    localparam int POS_W       = 10;
    localparam int CNT_W       = 10;
    localparam int IDX_W       = 12;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SA_W        = $clog2(STACK_DEPTH);
    localparam int TA_W        = $clog2(TABLE_DEPTH);
    localparam int TK_W        = $clog2(TABLE_DEPTH + 1);
    localparam int NW          = (CNT_W > SP_W) ? CNT_W : SP_W;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 56;

    typedef enum logic [1:0] {
        SYM_DOT, SYM_OPEN, SYM_CLOSE, SYM_IGNORE
    } t_symbol;

    typedef enum logic [2:0] {
        LT_HAIRPIN, LT_STACK, LT_BULGE, LT_INTERIOR,
        LT_MULTI_IN, LT_MULTI_OUT, LT_EXTERNAL
    } t_loop_type;

    typedef enum logic [1:0] {
        ST_OK, ST_UNMATCHED, ST_OVERFLOW, ST_FULL
    } t_status;

    typedef struct packed {
        logic             from_first;
        t_loop_type       ltype;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] d;
    } t_loop_rec;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
    } t_pair;

    typedef struct packed {
        logic [POS_W-1:0] i;
        logic [POS_W-1:0] j;
    } t_child;

    typedef struct packed {
        logic      drain;
        t_loop_rec rec;
    } t_tbl_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic full;
    } t_tbl_rsp;

    function automatic logic [IDX_W-1:0] ext(input logic [POS_W-1:0] p);
        return IDX_W'(p);
    endfunction

    function automatic t_status smax(input t_status x, input t_status y);
        return (x > y) ? x : y;
    endfunction

    function automatic t_loop_rec mk_rec(input logic f, input t_loop_type t,
                                         input logic [IDX_W-1:0] a,
                                         input logic [IDX_W-1:0] b,
                                         input logic [IDX_W-1:0] c,
                                         input logic [IDX_W-1:0] d);
        t_loop_rec r;
        r.from_first = f;
        r.ltype      = t;
        r.a          = a;
        r.b          = b;
        r.c          = c;
        r.d          = d;
        return r;
    endfunction
endpackage

[rtl/rna_loop_difference_engine.sv]
// Top level: pair and child stacks, close classification, output word register
//
// Symbols of two dot-bracket structures enter one word at a time; each closing
// bracket is classified from its opening partner's child count and the closed
// children, and every resulting loop record toggles a 64-entry loop table, so
// loops common to both structures cancel. A drain word streams the surviving
// records in slot order (tlast on the final one, or a single empty marker) and
// clears the table. Each table toggle scans the table memory one entry per cycle
// (a matching record ends the scan early), so a hairpin, stack, bulge or interior
// close takes one scan, a multiloop close one more scan per child, and a close of
// an outermost pair one further scan. A drain walks every table slot and slows
// down if the sink stalls. Errors return one status word.
module rna_loop_difference_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lde_pkg::S_DATA_W-1:0] s_tdata,  // symbol[1:0], position[11:2], from_first[12]
    input  logic                         s_tuser,  // cmd
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lde_pkg::M_DATA_W-1:0] m_tdata,  // loop_from_first[0], loop_type[3:1],
                                                   // idx_a[15:4], idx_b[27:16], idx_c[39:28],
                                                   // idx_d[51:40], status[53:52]
    output logic                         m_tuser,  // valid_res
    output logic                         m_tlast   // last
);
    import lde_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_OPEN_RD, S_OPEN_WR, S_CLOSE_RD, S_TGO, S_TWAIT, S_CH, S_CH_RD,
        S_FIN, S_DONE, S_ERR, S_DGO, S_DRAIN
    } t_state;

    typedef enum logic [1:0] {PH_MAIN, PH_CHILD, PH_EXT} t_phase;

    t_state           r_state;
    t_phase           r_phase;
    logic [POS_W-1:0] r_pos;
    logic             r_from;
    logic [SP_W-1:0]  r_psp;
    logic [SP_W-1:0]  r_csp;
    logic [SP_W-1:0]  r_base;
    logic [SP_W-1:0]  r_ck;
    logic [POS_W-1:0] r_i;
    logic             r_multi;
    logic [POS_W-1:0] r_last_i;
    logic [POS_W-1:0] r_last_j;
    t_status          r_err;
    t_loop_rec        r_rec;
    logic             r_req_drain;

    // output word register
    logic             r_mvalid;
    t_loop_rec        r_mrec;
    t_status          r_mstatus;
    logic             r_mres;
    logic             r_mlast;
    logic             w_mload;

    // stack memories
    logic             w_p_we;
    logic [SA_W-1:0]  w_p_waddr;
    t_pair            w_p_wdata;
    t_pair            w_p_rdata;
    logic             w_c_we;
    t_child           w_c_rdata;

    // table link
    logic             w_req_valid;
    t_tbl_req         w_req;
    t_tbl_rsp         w_rsp;
    logic             w_emit_valid;
    t_loop_rec        w_emit_rec;
    logic             w_emit_any;
    logic             w_emit_last;
    logic             w_slot_free;

    // close classification
    logic [NW-1:0]    w_nch;
    logic [IDX_W-1:0] w_ci;
    logic [IDX_W-1:0] w_cj;
    logic [IDX_W-1:0] w_li;
    logic [IDX_W-1:0] w_lj;
    t_loop_type       w_one_type;
    logic [CNT_W-1:0] w_cnt_inc;

    logic             w_acc;

    lde_ram #(.WIDTH($bits(t_pair)), .DEPTH(STACK_DEPTH)) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_p_waddr),
        .i_wdata (w_p_wdata),
        .i_raddr (SA_W'(r_psp - SP_W'(1))),
        .o_rdata (w_p_rdata)
    );

    lde_ram #(.WIDTH($bits(t_child)), .DEPTH(STACK_DEPTH)) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (r_base[SA_W-1:0]),
        .i_wdata ({r_i, r_pos}),
        .i_raddr (r_ck[SA_W-1:0]),
        .o_rdata (w_c_rdata)
    );

    lde_loop_table u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (w_req_valid),
        .i_req        (w_req),
        .o_rsp        (w_rsp),
        .o_emit_valid (w_emit_valid),
        .o_emit_rec   (w_emit_rec),
        .o_emit_any   (w_emit_any),
        .o_emit_last  (w_emit_last),
        .i_emit_ready (w_slot_free && (r_state == S_DRAIN))
    );

    // handshake and ports
    always_comb begin
        s_tready    = (r_state == S_IDLE);
        w_acc       = s_tvalid && s_tready;
        w_slot_free = !r_mvalid || m_tready;
        w_mload     = w_slot_free &&
                      ((r_state == S_ERR) || ((r_state == S_DRAIN) && w_emit_valid));
        w_req_valid = (r_state == S_TGO) || (r_state == S_DGO);
        w_req.drain = r_req_drain;
        w_req.rec   = r_rec;
        m_tvalid    = r_mvalid;
        m_tuser     = r_mres;
        m_tlast     = r_mlast;
        m_tdata     = {2'b00, r_mstatus, r_mrec.d, r_mrec.c, r_mrec.b, r_mrec.a,
                       r_mrec.ltype, r_mrec.from_first};
    end

    // stack writes
    always_comb begin
        w_cnt_inc = (w_p_rdata.cnt < CNT_MAX) ? w_p_rdata.cnt + CNT_W'(1) : w_p_rdata.cnt;
        w_p_we    = (r_state == S_OPEN_RD) || (r_state == S_OPEN_WR);
        if (r_state == S_OPEN_RD) begin
            w_p_waddr = SA_W'(r_psp - SP_W'(1));
            w_p_wdata = '{pos: w_p_rdata.pos, cnt: w_cnt_inc};
        end else begin
            w_p_waddr = r_psp[SA_W-1:0];
            w_p_wdata = '{pos: r_pos, cnt: '0};
        end
        w_c_we = (r_state == S_FIN) && (r_psp != '0) && (r_base < SP_W'(STACK_DEPTH));
    end

    // close classification from the popped pair
    always_comb begin
        w_nch = (NW'(w_p_rdata.cnt) < NW'(r_csp)) ? NW'(w_p_rdata.cnt) : NW'(r_csp);
        w_ci  = ext(w_p_rdata.pos);
        w_cj  = ext(r_pos);
        w_li  = ext(r_last_i);
        w_lj  = ext(r_last_j);
        if (w_li == w_ci + IDX_W'(1) && w_lj == w_cj - IDX_W'(1)) begin
            w_one_type = LT_STACK;
        end else if (w_li == w_ci + IDX_W'(1) || w_lj == w_cj - IDX_W'(1)) begin
            w_one_type = LT_BULGE;
        end else begin
            w_one_type = LT_INTERIOR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_psp    <= '0;
            r_csp    <= '0;
            r_last_i <= '0;
            r_last_j <= '0;
            r_mvalid <= 1'b0;
            r_err    <= ST_OK;
        end else begin
            // output word valid: load wins over a drained slot
            if (w_mload) begin
                r_mvalid <= 1'b1;
            end else if (m_tready) begin
                r_mvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_pos       <= s_tdata[11:2];
                        r_from      <= s_tdata[12];
                        r_err       <= ST_OK;
                        r_req_drain <= s_tuser;
                        if (s_tuser) begin
                            r_state <= S_DGO;
                        end else begin
                            unique case (t_symbol'(s_tdata[1:0]))
                                SYM_OPEN: begin
                                    if (r_psp >= SP_W'(STACK_DEPTH)) begin
                                        r_err   <= ST_OVERFLOW;
                                        r_state <= S_ERR;
                                    end else if (r_psp != '0) begin
                                        r_state <= S_OPEN_RD;
                                    end else begin
                                        r_state <= S_OPEN_WR;
                                    end
                                end
                                SYM_CLOSE: begin
                                    if (r_psp == '0) begin
                                        r_err   <= ST_UNMATCHED;
                                        r_state <= S_ERR;
                                    end else begin
                                        r_state <= S_CLOSE_RD;
                                    end
                                end
                                SYM_DOT, SYM_IGNORE: r_state <= S_IDLE;
                                default: r_state <= S_IDLE;
                            endcase
                        end
                    end
                end
                S_OPEN_RD: r_state <= S_OPEN_WR;
                S_OPEN_WR: begin
                    r_psp   <= r_psp + SP_W'(1);
                    r_state <= S_DONE;
                end
                // popped pair is in the read register now
                S_CLOSE_RD: begin
                    r_psp   <= r_psp - SP_W'(1);
                    r_i     <= w_p_rdata.pos;
                    r_base  <= r_csp - SP_W'(w_nch);
                    r_multi <= (w_p_rdata.cnt > CNT_W'(1));
                    r_phase <= PH_MAIN;
                    if (w_p_rdata.cnt == '0) begin
                        r_rec <= mk_rec(r_from, LT_HAIRPIN, w_ci, w_cj,
                                        w_ci + IDX_W'(1), w_cj - IDX_W'(1));
                    end else if (w_p_rdata.cnt == CNT_W'(1)) begin
                        r_rec <= mk_rec(r_from, w_one_type, w_ci, w_cj, w_li, w_lj);
                    end else begin
                        r_rec <= mk_rec(r_from, LT_MULTI_OUT, w_ci, w_cj,
                                        w_ci + IDX_W'(1), w_cj - IDX_W'(1));
                    end
                    r_state <= S_TGO;
                end
                S_TGO: r_state <= S_TWAIT;
                S_TWAIT: begin
                    if (w_rsp.done) begin
                        if (w_rsp.full) begin
                            r_err <= smax(r_err, ST_FULL);
                        end
                        unique case (r_phase)
                            PH_MAIN: begin
                                r_ck    <= r_base;
                                r_state <= r_multi ? S_CH : S_FIN;
                            end
                            PH_CHILD: begin
                                r_ck    <= r_ck + SP_W'(1);
                                r_state <= S_CH;
                            end
                            PH_EXT: r_state <= S_DONE;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                // walk the recorded children of a multiloop
                S_CH: r_state <= (r_ck == r_csp) ? S_FIN : S_CH_RD;
                S_CH_RD: begin
                    r_rec   <= mk_rec(r_from, LT_MULTI_IN, ext(w_c_rdata.i), ext(w_c_rdata.j),
                                      ext(w_c_rdata.i) - IDX_W'(1),
                                      ext(w_c_rdata.j) + IDX_W'(1));
                    r_phase <= PH_CHILD;
                    r_state <= S_TGO;
                end
                S_FIN: begin
                    r_last_i <= r_i;
                    r_last_j <= r_pos;
                    if (r_psp != '0) begin
                        if (r_base >= SP_W'(STACK_DEPTH)) begin
                            r_err <= smax(r_err, ST_OVERFLOW);
                            r_csp <= r_base;
                        end else begin
                            r_csp <= r_base + SP_W'(1);
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_csp   <= r_base;
                        r_rec   <= mk_rec(r_from, LT_EXTERNAL, ext(r_i), ext(r_pos),
                                          ext(r_i) - IDX_W'(1), ext(r_pos) + IDX_W'(1));
                        r_phase <= PH_EXT;
                        r_state <= S_TGO;
                    end
                end
                S_DONE: r_state <= (r_err != ST_OK) ? S_ERR : S_IDLE;
                S_ERR: begin
                    if (w_slot_free) begin
                        r_mrec    <= '0;
                        r_mres    <= 1'b0;
                        r_mlast   <= 1'b0;
                        r_mstatus <= r_err;
                        r_state   <= S_IDLE;
                    end
                end
                S_DGO: r_state <= S_DRAIN;
                S_DRAIN: begin
                    if (w_emit_valid && w_slot_free) begin
                        r_mrec    <= w_emit_rec;
                        r_mres    <= w_emit_any;
                        r_mlast   <= w_emit_last;
                        r_mstatus <= ST_OK;
                    end
                    if (w_rsp.done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_psp_range, i_clk, i_rst_n, r_psp <= SP_W'(STACK_DEPTH), "pair stack pointer out of range")
    `ASSERT_ALWAYS(a_csp_range, i_clk, i_rst_n, r_csp <= SP_W'(STACK_DEPTH), "child stack pointer out of range")
    `ASSERT_IMPLIES(a_req_idle, i_clk, i_rst_n, w_req_valid, !w_rsp.busy, "table request while table busy")
endmodule

[rtl/lde_ram.sv]
// Generic single-write, single-read RAM with registered read data
module lde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/lde_loop_table.sv]
// Loop table: toggle search/insert and drain of surviving records
module lde_loop_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  lde_pkg::t_tbl_req  i_req,
    output lde_pkg::t_tbl_rsp  o_rsp,
    output logic               o_emit_valid,
    output lde_pkg::t_loop_rec o_emit_rec,
    output logic               o_emit_any,
    output logic               o_emit_last,
    input  logic               i_emit_ready
);
    import lde_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {T_IDLE, T_SCAN, T_DRN, T_DWAIT, T_DEMPTY} t_tstate;

    t_tstate          r_state;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TK_W-1:0]  r_k;
    logic             r_cmp_v;
    logic [TA_W-1:0]  r_cmp_k;
    logic             r_free_v;
    logic [TA_W-1:0]  r_free;
    t_loop_rec        r_rec;
    logic             r_any;
    logic             r_done;
    logic             r_full;

    logic             w_we;
    t_loop_rec        w_rdata;
    logic             w_hit;
    logic             w_empty_slot;
    logic             w_free_v;
    logic [TA_W-1:0]  w_free;
    logic             w_end;
    logic             w_none_above;
    logic             w_done;
    logic             w_full;

    lde_ram #(.WIDTH($bits(t_loop_rec)), .DEPTH(TABLE_DEPTH)) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_free),
        .i_wdata (r_rec),
        .i_raddr (r_k[TA_W-1:0]),
        .o_rdata (w_rdata)
    );

    // compare the entry read last cycle
    always_comb begin
        w_hit = r_cmp_v && r_valid[r_cmp_k] && (w_rdata.ltype == r_rec.ltype) &&
                (w_rdata.a == r_rec.a) && (w_rdata.b == r_rec.b) &&
                (w_rdata.c == r_rec.c) && (w_rdata.d == r_rec.d);
        w_empty_slot = r_cmp_v && !r_valid[r_cmp_k];
        w_free_v     = r_free_v || w_empty_slot;
        w_free       = r_free_v ? r_free : r_cmp_k;
        w_end        = (r_k == TK_W'(TABLE_DEPTH)) && r_cmp_v && !w_hit;
        w_we         = (r_state == T_SCAN) && w_end && w_free_v;
        w_none_above = ((r_valid >> r_k[TA_W-1:0]) >> 1) == '0;
        w_done       = ((r_state == T_SCAN) && (w_hit || w_end)) ||
                       ((r_state == T_DRN) && (r_k == TK_W'(TABLE_DEPTH)) && r_any) ||
                       ((r_state == T_DEMPTY) && i_emit_ready);
        w_full       = (r_state == T_SCAN) && w_end && !w_free_v;
    end

    // drain stream and response
    always_comb begin
        o_emit_valid = (r_state == T_DWAIT) || (r_state == T_DEMPTY);
        o_emit_any   = (r_state == T_DWAIT);
        o_emit_rec   = (r_state == T_DWAIT) ? w_rdata : '0;
        o_emit_last  = (r_state == T_DEMPTY) || w_none_above;
        o_rsp.busy   = (r_state != T_IDLE);
        o_rsp.done   = r_done;
        o_rsp.full   = r_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_valid <= '0;
            r_done  <= 1'b0;
            r_full  <= 1'b0;
            r_cmp_v <= 1'b0;
        end else begin
            r_done <= w_done;
            r_full <= w_full;
            unique case (r_state)
                T_IDLE: begin
                    if (i_req_valid) begin
                        r_rec    <= i_req.rec;
                        r_k      <= '0;
                        r_cmp_v  <= 1'b0;
                        r_free_v <= 1'b0;
                        r_any    <= 1'b0;
                        r_state  <= i_req.drain ? T_DRN : T_SCAN;
                    end
                end
                T_SCAN: begin
                    r_cmp_v <= (r_k != TK_W'(TABLE_DEPTH)) && !w_hit;
                    r_cmp_k <= r_k[TA_W-1:0];
                    if (r_k != TK_W'(TABLE_DEPTH)) begin
                        r_k <= r_k + TK_W'(1);
                    end
                    if (w_empty_slot && !r_free_v) begin
                        r_free_v <= 1'b1;
                        r_free   <= r_cmp_k;
                    end
                    if (w_hit) begin
                        r_valid[r_cmp_k] <= 1'b0;
                        r_state          <= T_IDLE;
                    end else if (w_end) begin
                        if (w_free_v) begin
                            r_valid[w_free] <= 1'b1;
                        end
                        r_state <= T_IDLE;
                    end
                end
                T_DRN: begin
                    if (r_k == TK_W'(TABLE_DEPTH)) begin
                        if (r_any) begin
                            r_valid <= '0;
                            r_state <= T_IDLE;
                        end else begin
                            r_state <= T_DEMPTY;
                        end
                    end else if (r_valid[r_k[TA_W-1:0]]) begin
                        r_state <= T_DWAIT;
                    end else begin
                        r_k <= r_k + TK_W'(1);
                    end
                end
                T_DWAIT: begin
                    if (i_emit_ready) begin
                        r_k     <= r_k + TK_W'(1);
                        r_any   <= 1'b1;
                        r_state <= T_DRN;
                    end
                end
                T_DEMPTY: begin
                    if (i_emit_ready) begin
                        r_valid <= '0;
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_dwait_valid, i_clk, i_rst_n, r_state == T_DWAIT, r_valid[r_k[TA_W-1:0]], "drain emitting an invalid slot")
    `ASSERT_IMPLIES(a_full_only_when_full, i_clk, i_rst_n, r_full, &r_valid, "table full flagged with a free slot")
endmodule
